[rtl/core/q4_q8_block_dot_product_assert.svh]
// Assertion helpers used by the core RTL top module.
`ifndef Q4_Q8_BLOCK_DOT_PRODUCT_ASSERT_SVH
`define Q4_Q8_BLOCK_DOT_PRODUCT_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define QDP_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked out of reset.
`define QDP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/core/qdp_pkg.sv]
package qdp_pkg;

	localparam int BYTES_PER_ITEM_DEF = 8;
	localparam int MAX_LANES          = 8;
	localparam logic [4:0] CODE_BIAS  = 5'd8;
	localparam logic [31:0] FP32_DEFAULT_NAN = 32'hFFC0_0000;
	localparam logic [31:0] FP32_QUIET_BIT   = 32'h0040_0000;

	typedef enum logic [0:0] {
		FP_MUL = 1'b0,
		FP_ADD = 1'b1
	} fp_op_t;

	// fp16 bits to fp32 bits, exact (fp16 subnormals are fp32 normals)
	function automatic logic [31:0] fp16_to_fp32(input logic [15:0] h);
		logic       s;
		logic [4:0] e;
		logic [9:0] m;
		logic [3:0] pos;
		logic [31:0] r;
		s   = h[15];
		e   = h[14:10];
		m   = h[9:0];
		pos = 4'd0;
		r   = '0;
		if (e == 5'd0) begin
			if (m == 10'd0) begin
				r = {s, 31'd0};
			end else begin
				for (int i = 0; i < 10; i++) begin
					if (m[i]) pos = 4'(i);
				end
				r = {s, 8'(8'd103 + 8'(pos)), 23'(({13'd0, m} << (5'd23 - 5'(pos))))};
			end
		end else if (e == 5'd31) begin
			r = {s, 8'hFF, m, 13'd0};
		end else begin
			r = {s, 8'(8'(e) + 8'd112), m, 13'd0};
		end
		return r;
	endfunction

	// 17-bit signed integer to fp32 bits, exact
	function automatic logic [31:0] int17_to_fp32(input logic signed [16:0] v);
		logic        s;
		logic [16:0] mag;
		logic [4:0]  pos;
		logic [31:0] r;
		s   = v[16];
		mag = s ? 17'(-v) : 17'(v);
		pos = 5'd0;
		r   = '0;
		for (int i = 0; i < 17; i++) begin
			if (mag[i]) pos = 5'(i);
		end
		if (mag != 17'd0) begin
			r = {s, 8'(8'd127 + 8'(pos)), 23'(({6'd0, mag} << (5'd23 - pos)))};
		end
		return r;
	endfunction

endpackage

[rtl/core/qdp_lanes.sv]
module qdp_lanes import qdp_pkg::*; #(
	parameter int BYTES_PER_ITEM = BYTES_PER_ITEM_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [63:0]        nibbles,
	input  logic [63:0]        act_lo,
	input  logic [63:0]        act_hi,
	output logic               done,
	output logic signed [16:0] part
);

	localparam int LANES = (BYTES_PER_ITEM > MAX_LANES) ? MAX_LANES : BYTES_PER_ITEM;

	logic signed [12:0] pair_d  [LANES];
	logic signed [12:0] pair_s1 [LANES];
	logic signed [16:0] part_d;
	logic signed [16:0] part_s2;
	logic               valid_s1;
	logic               valid_s2;

	// each lane: (lo code - 8) * lo act + (hi code - 8) * hi act
	always_comb begin
		for (int i = 0; i < LANES; i++) begin
			pair_d[i] = 13'(13'($signed(5'({1'b0, nibbles[8*i +: 4]}) - CODE_BIAS))
				* 13'($signed(act_lo[8*i +: 8])))
				+ 13'(13'($signed(5'({1'b0, nibbles[8*i+4 +: 4]}) - CODE_BIAS))
				* 13'($signed(act_hi[8*i +: 8])));
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < LANES; i++) begin
			pair_s1[i] <= pair_d[i];
		end
	end

	// merge the lane results
	always_comb begin
		part_d = '0;
		for (int i = 0; i < LANES; i++) begin
			part_d = part_d + 17'(pair_s1[i]);
		end
	end

	always_ff @(posedge clk) begin
		part_s2 <= part_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= start;
			valid_s2 <= valid_s1;
		end
	end

	assign done = valid_s2;
	assign part = part_s2;

endmodule

[rtl/core/qdp_fpu.sv]
module qdp_fpu import qdp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  fp_op_t      op,
	input  logic [31:0] a,
	input  logic [31:0] b,
	output logic        done,
	output logic [31:0] result
);

	logic        valid_s1;
	fp_op_t      op_s1;
	logic        spec_s1;
	logic [31:0] spec_val_s1;
	logic        sign_s1;
	logic signed [9:0] exp_s1;
	logic [47:0] mant_s1;

	logic        valid_s2;
	logic [31:0] res_s2;

	logic        spec_d;
	logic [31:0] spec_val_d;
	logic        sign_d;
	logic signed [9:0] exp_d;
	logic [47:0] mant_d;

	logic        sa, sb, nan_a, nan_b, inf_a, inf_b, zero_a, zero_b, a_big;
	logic [7:0]  ea, eb, e_big, e_sml, diff;
	logic [22:0] fa, fb;
	logic [23:0] m_big, m_sml;
	logic [55:0] wide;
	logic [26:0] big27, sml27;

	function automatic logic [31:0] round_pack(input logic s, input logic signed [9:0] e,
		input logic [23:0] m, input logic g, input logic st);
		logic [24:0] mr;
		logic signed [9:0] er;
		logic [31:0] r;
		mr = {1'b0, m} + 25'(g & (st | m[0]));
		er = e;
		if (mr[24]) begin
			mr = mr >> 1;
			er = er + 10'sd1;
		end
		if (er >= 10'sd255) r = {s, 8'hFF, 23'd0};
		else if (er <= 10'sd0) r = {s, 31'd0};
		else r = {s, er[7:0], mr[22:0]};
		return r;
	endfunction

	always_comb begin
		sa = a[31]; ea = a[30:23]; fa = a[22:0];
		sb = b[31]; eb = b[30:23]; fb = b[22:0];
		nan_a  = (ea == 8'hFF) && (fa != 23'd0);
		nan_b  = (eb == 8'hFF) && (fb != 23'd0);
		inf_a  = (ea == 8'hFF) && (fa == 23'd0);
		inf_b  = (eb == 8'hFF) && (fb == 23'd0);
		zero_a = (ea == 8'd0);
		zero_b = (eb == 8'd0);
		a_big  = a[30:0] >= b[30:0];
		e_big  = a_big ? ea : eb;
		e_sml  = a_big ? eb : ea;
		m_big  = a_big ? {1'b1, fa} : {1'b1, fb};
		m_sml  = a_big ? {1'b1, fb} : {1'b1, fa};
		diff   = e_big - e_sml;
		wide   = {m_sml, 32'd0} >> ((diff > 8'd31) ? 5'd31 : diff[4:0]);
		big27  = {m_big, 3'd0};
		sml27  = wide[55:29] | {26'd0, |wide[28:0]};
		spec_d     = 1'b1;
		spec_val_d = '0;
		sign_d     = 1'b0;
		exp_d      = '0;
		mant_d     = '0;
		case (op)
			FP_MUL: begin
				sign_d = sa ^ sb;
				if (nan_a) spec_val_d = a | FP32_QUIET_BIT;
				else if (nan_b) spec_val_d = b | FP32_QUIET_BIT;
				else if ((inf_a && zero_b) || (zero_a && inf_b)) spec_val_d = FP32_DEFAULT_NAN;
				else if (inf_a || inf_b) spec_val_d = {sa ^ sb, 8'hFF, 23'd0};
				else if (zero_a || zero_b) spec_val_d = {sa ^ sb, 31'd0};
				else begin
					spec_d = 1'b0;
					exp_d  = 10'($signed({2'b0, ea})) + 10'($signed({2'b0, eb})) - 10'sd127;
					mant_d = {24'd0, 1'b1, fa} * {24'd0, 1'b1, fb};
				end
			end
			FP_ADD: begin
				sign_d = a_big ? sa : sb;
				if (nan_a) spec_val_d = a | FP32_QUIET_BIT;
				else if (nan_b) spec_val_d = b | FP32_QUIET_BIT;
				else if (inf_a && inf_b && (sa != sb)) spec_val_d = FP32_DEFAULT_NAN;
				else if (inf_a) spec_val_d = a;
				else if (inf_b) spec_val_d = b;
				else if (zero_a && zero_b) spec_val_d = {sa & sb, 31'd0};
				else if (zero_a) spec_val_d = b;
				else if (zero_b) spec_val_d = a;
				else if ((a[30:0] == b[30:0]) && (sa != sb)) spec_val_d = 32'd0;
				else begin
					spec_d = 1'b0;
					exp_d  = 10'($signed({2'b0, e_big}));
					mant_d = (sa != sb) ? 48'({1'b0, big27} - {1'b0, sml27})
						: 48'({1'b0, big27} + {1'b0, sml27});
				end
			end
			default: begin
				spec_val_d = FP32_DEFAULT_NAN;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		op_s1       <= op;
		spec_s1     <= spec_d;
		spec_val_s1 <= spec_val_d;
		sign_s1     <= sign_d;
		exp_s1      <= exp_d;
		mant_s1     <= mant_d;
	end

	logic [26:0] m27;
	logic [4:0]  pos;
	logic [4:0]  lz;
	logic signed [9:0] e2;
	logic [31:0] res_d;

	// normalize and round
	always_comb begin
		m27   = '0;
		pos   = '0;
		lz    = '0;
		e2    = exp_s1;
		res_d = spec_val_s1;
		case (op_s1)
			FP_MUL: begin
				if (mant_s1[47]) begin
					res_d = round_pack(sign_s1, exp_s1 + 10'sd1, mant_s1[47:24],
						mant_s1[23], |mant_s1[22:0]);
				end else begin
					res_d = round_pack(sign_s1, exp_s1, mant_s1[46:23],
						mant_s1[22], |mant_s1[21:0]);
				end
			end
			FP_ADD: begin
				if (mant_s1[27]) begin
					m27 = mant_s1[27:1] | {26'd0, mant_s1[0]};
					e2  = exp_s1 + 10'sd1;
				end else begin
					for (int i = 0; i < 27; i++) begin
						if (mant_s1[i]) pos = 5'(i);
					end
					lz  = 5'd26 - pos;
					m27 = mant_s1[26:0] << lz;
					e2  = exp_s1 - 10'($signed({5'd0, lz}));
				end
				res_d = round_pack(sign_s1, e2, m27[26:3], m27[2], |m27[1:0]);
			end
			default: begin
				res_d = FP32_DEFAULT_NAN;
			end
		endcase
		if (spec_s1) res_d = spec_val_s1;
	end

	always_ff @(posedge clk) begin
		res_s2 <= res_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= start;
			valid_s2 <= valid_s1;
		end
	end

	assign done   = valid_s2;
	assign result = res_s2;

endmodule

[rtl/core/q4_q8_block_dot_product.sv]
// Q4 x Q8 block dot product, one half-block (8 weight bytes) per input transfer.
// Input channel: in_valid / in_stall with the weight nibbles, both activation
// words, the two fp16 scales and last_of_row. Scales matter on second halves only.
// Output channel: out_valid / out_stall with sum_bits, the fp32 dot product,
// one transfer per last_of_row item.
// The eight lanes form nibble x activation products; a merge stage sums them.
// A first half passes the two lane/merge stages plus the control step.
// A second half passes the lanes, int-to-fp32, then two fp32 multiplies
// and one fp32 add on the shared two-stage float unit; a last_of_row item
// then loads the output register. in_stall is high while an item is
// in flight. The float unit sets the rate.
// Results sit in an output register; a stalled receiver holds it, and the block
// keeps taking items until a new result must be loaded into a full register.
// Reset clears the half index, block sum and running sum (+0.0).
module q4_q8_block_dot_product import qdp_pkg::*; #(
	parameter int BYTES_PER_ITEM = BYTES_PER_ITEM_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [63:0] packed_nibbles,
	input  logic [63:0] low_activations,
	input  logic [63:0] high_activations,
	input  logic [15:0] weight_scale,
	input  logic [15:0] activation_scale,
	input  logic        last_of_row,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] sum_bits
);

	`include "q4_q8_block_dot_product_assert.svh"

	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001,
		ST_LANE = 7'b0000010,
		ST_CVT  = 7'b0000100,
		ST_MUL1 = 7'b0001000,
		ST_MUL2 = 7'b0010000,
		ST_ADD  = 7'b0100000,
		ST_EMIT = 7'b1000000
	} state_t;

	state_t             state_q;
	logic               half_q;
	logic signed [16:0] block_q;
	logic signed [16:0] sumi_q;
	logic [31:0]        run_q;
	logic [31:0]        tmp_q;
	logic [15:0]        wscale_q;
	logic [15:0]        ascale_q;
	logic               last_q;
	logic               start_q;
	logic               out_valid_q;
	logic [31:0]        out_data_q;

	logic               accept;
	logic               lane_done;
	logic signed [16:0] lane_part;
	logic               fpu_done;
	logic [31:0]        fpu_res;
	fp_op_t             fpu_op;
	logic [31:0]        fpu_a;
	logic [31:0]        fpu_b;
	logic               out_free;

	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	qdp_lanes #(
		.BYTES_PER_ITEM(BYTES_PER_ITEM)
	) u_lanes (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (accept),
		.nibbles(packed_nibbles),
		.act_lo (low_activations),
		.act_hi (high_activations),
		.done   (lane_done),
		.part   (lane_part)
	);

	always_comb begin
		fpu_op = FP_MUL;
		fpu_a  = tmp_q;
		fpu_b  = fp16_to_fp32(wscale_q);
		case (state_q)
			ST_MUL2: begin
				fpu_b = fp16_to_fp32(ascale_q);
			end
			ST_ADD: begin
				fpu_op = FP_ADD;
				fpu_a  = run_q;
				fpu_b  = tmp_q;
			end
			default: begin
			end
		endcase
	end

	qdp_fpu u_fpu (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start_q),
		.op    (fpu_op),
		.a     (fpu_a),
		.b     (fpu_b),
		.done  (fpu_done),
		.result(fpu_res)
	);

	always_ff @(posedge clk) begin
		if (accept) begin
			wscale_q <= weight_scale;
			ascale_q <= activation_scale;
			last_q   <= last_of_row;
		end
		if (state_q == ST_LANE && lane_done) sumi_q <= block_q + lane_part;
		if (state_q == ST_CVT) tmp_q <= int17_to_fp32(sumi_q);
		if (fpu_done && (state_q == ST_MUL1 || state_q == ST_MUL2)) tmp_q <= fpu_res;
		if (state_q == ST_EMIT && out_free) out_data_q <= run_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			half_q      <= 1'b0;
			block_q     <= '0;
			run_q       <= '0;
			start_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// one-cycle kick of the float unit for each float step
			start_q <= (state_q == ST_CVT)
				|| (fpu_done && (state_q == ST_MUL1 || state_q == ST_MUL2));
			if (state_q == ST_EMIT && out_free) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) state_q <= ST_LANE;
				end
				ST_LANE: begin
					if (lane_done) begin
						if (half_q) begin
							half_q  <= 1'b0;
							block_q <= '0;
							state_q <= ST_CVT;
						end else if (last_q) begin
							// partial block dropped
							state_q <= ST_EMIT;
						end else begin
							block_q <= lane_part;
							half_q  <= 1'b1;
							state_q <= ST_IDLE;
						end
					end
				end
				ST_CVT: begin
					state_q <= ST_MUL1;
				end
				ST_MUL1: begin
					if (fpu_done) begin
						state_q <= ST_MUL2;
					end
				end
				ST_MUL2: begin
					if (fpu_done) begin
						state_q <= ST_ADD;
					end
				end
				ST_ADD: begin
					if (fpu_done) begin
						run_q   <= fpu_res;
						state_q <= last_q ? ST_EMIT : ST_IDLE;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						run_q   <= '0;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign sum_bits  = out_data_q;

	`QDP_ASSERT_NEXT(a_accept_to_lane, clk, arst_n, accept, state_q == ST_LANE, "accept did not start lanes")
	`QDP_ASSERT_NOW(a_block_clear, clk, arst_n, !half_q, block_q == '0, "block sum left over")
	`QDP_ASSERT_NOW(a_fpu_done_state, clk, arst_n, fpu_done, state_q == ST_MUL1 || state_q == ST_MUL2 || state_q == ST_ADD, "float result outside a float step")
	`QDP_ASSERT_NOW(a_lane_done_state, clk, arst_n, lane_done, state_q == ST_LANE, "lane result outside lane step")

endmodule

[test/q4_q8_block_dot_product_tb.sv]
`timescale 1ns / 100ps

module q4_q8_block_dot_product_tb;
	import qdp_pkg::*;

	typedef struct {
		logic [63:0] nib;
		logic [63:0] act_lo;
		logic [63:0] act_hi;
		logic [15:0] wscale;
		logic [15:0] ascale;
		logic        last;
	} half_blk_t;

	localparam int LANES = (BYTES_PER_ITEM_DEF > MAX_LANES) ? MAX_LANES : BYTES_PER_ITEM_DEF;
	localparam logic [31:0] FP32_INF = 32'h7F80_0000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b1;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [63:0] packed_nibbles = '0;
	logic [63:0] low_activations = '0;
	logic [63:0] high_activations = '0;
	logic [15:0] weight_scale = '0;
	logic [15:0] activation_scale = '0;
	logic        last_of_row = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [31:0] sum_bits;

	half_blk_t   pending[$];
	half_blk_t   cur;
	logic [31:0] sum_expect[$];
	int          send_idle = 0;
	int          recv_idle = 0;
	bit          hold_in = 1'b0;
	int          fails = 0;

	// predictor state
	bit          pr_second;
	int          pr_blk_sum;
	logic [31:0] pr_running;

	q4_q8_block_dot_product dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.packed_nibbles(packed_nibbles), .low_activations(low_activations),
		.high_activations(high_activations), .weight_scale(weight_scale),
		.activation_scale(activation_scale), .last_of_row(last_of_row),
		.out_valid(out_valid), .out_stall(out_stall), .sum_bits(sum_bits)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// value = m * 2^x, rounded to nearest even into fp32
	function automatic logic [31:0] fp32_round(input logic s, input logic [127:0] m, input int x);
		int p, q, sh;
		logic [127:0] r;
		logic g, st;
		p = 0;
		g = 1'b0;
		st = 1'b0;
		if (m == '0) return {s, 31'd0};
		for (int i = 0; i < 128; i++)
			if (m[i]) p = i;
		q = p + x - 23;
		if (q < -149) q = -149;
		sh = q - x;
		if (sh <= 0) begin
			r = m << (-sh);
		end else if (sh > 128) begin
			r = '0;
			st = 1'b1;
		end else begin
			r = m >> sh;
			g = m[sh-1];
			st = (m & ((128'd1 << (sh - 1)) - 1)) != '0;
		end
		if (g && (st || r[0])) r = r + 1;
		if (r == (128'd1 << 24)) begin
			r = r >> 1;
			q++;
		end
		if (r < (128'd1 << 23)) return {s, 8'd0, r[22:0]};
		if (q + 150 >= 255) return {s, 31'h7F80_0000};
		return {s, 8'(q + 150), r[22:0]};
	endfunction

	function automatic bit is_nan(input logic [31:0] a);
		return a[30:23] == 8'hFF && a[22:0] != '0;
	endfunction

	function automatic bit is_inf(input logic [31:0] a);
		return a[30:0] == FP32_INF[30:0];
	endfunction

	function automatic logic [23:0] sig_of(input logic [31:0] a);
		return (a[30:23] == 0) ? {1'b0, a[22:0]} : {1'b1, a[22:0]};
	endfunction

	function automatic int exp_of(input logic [31:0] a);
		return (a[30:23] == 0) ? -149 : int'(a[30:23]) - 150;
	endfunction

	function automatic logic [31:0] fp32_mul(input logic [31:0] a, input logic [31:0] b);
		logic s;
		s = a[31] ^ b[31];
		if (is_nan(a)) return a | FP32_QUIET_BIT;
		if (is_nan(b)) return b | FP32_QUIET_BIT;
		if ((is_inf(a) && b[30:0] == 0) || (is_inf(b) && a[30:0] == 0)) return FP32_DEFAULT_NAN;
		if (is_inf(a) || is_inf(b)) return {s, FP32_INF[30:0]};
		if (a[30:0] == 0 || b[30:0] == 0) return {s, 31'd0};
		return fp32_round(s, 128'(sig_of(a)) * 128'(sig_of(b)), exp_of(a) + exp_of(b));
	endfunction

	function automatic logic [31:0] fp32_add(input logic [31:0] a, input logic [31:0] b);
		logic [31:0] t;
		logic [127:0] big, tiny;
		int d;
		if (is_nan(a)) return a | FP32_QUIET_BIT;
		if (is_nan(b)) return b | FP32_QUIET_BIT;
		if (is_inf(a) && is_inf(b) && a[31] != b[31]) return FP32_DEFAULT_NAN;
		if (is_inf(a)) return a;
		if (is_inf(b)) return b;
		if (a[30:0] == 0 && b[30:0] == 0) return {a[31] & b[31], 31'd0};
		if (a[30:0] == 0) return b;
		if (b[30:0] == 0) return a;
		if (b[30:0] > a[30:0]) begin
			t = a;
			a = b;
			b = t;
		end
		d = exp_of(a) - exp_of(b);
		big = 128'(sig_of(a)) << 40;
		// far below the rounding point only the sticky matters
		tiny = (d <= 40) ? (128'(sig_of(b)) << (40 - d)) : 128'd1;
		if (a[31] == b[31]) return fp32_round(a[31], big + tiny, exp_of(a) - 40);
		if (big == tiny) return 32'd0;
		return fp32_round(a[31], big - tiny, exp_of(a) - 40);
	endfunction

	function automatic logic [31:0] half_to_single(input logic [15:0] h);
		if (h[14:10] == 0) return fp32_round(h[15], 128'(h[9:0]), -24);
		if (h[14:10] == 5'd31) return {h[15], 8'hFF, h[9:0], 13'd0};
		return {h[15], 8'(h[14:10]) + 8'd112, h[9:0], 13'd0};
	endfunction

	function automatic int lane_dot(input half_blk_t it);
		int acc;
		acc = 0;
		for (int i = 0; i < LANES; i++) begin
			acc += (int'(it.nib[8*i +: 4]) - 8) * int'($signed(it.act_lo[8*i +: 8]));
			acc += (int'(it.nib[8*i+4 +: 4]) - 8) * int'($signed(it.act_hi[8*i +: 8]));
		end
		return acc;
	endfunction

	task automatic predict_dot(input half_blk_t it);
		int s;
		logic [31:0] t;
		if (!pr_second) begin
			if (it.last) begin
				// partial block dropped
				sum_expect.push_back(pr_running);
				pr_running = 32'd0;
			end else begin
				pr_blk_sum = lane_dot(it);
				pr_second = 1'b1;
			end
			return;
		end
		s = pr_blk_sum + lane_dot(it);
		t = fp32_round(s < 0, 128'(s < 0 ? -s : s), 0);
		t = fp32_mul(t, half_to_single(it.wscale));
		t = fp32_mul(t, half_to_single(it.ascale));
		pr_running = fp32_add(pr_running, t);
		pr_blk_sum = 0;
		pr_second = 1'b0;
		if (it.last) begin
			sum_expect.push_back(pr_running);
			pr_running = 32'd0;
		end
	endtask

	// driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) predict_dot(cur);
			if (!in_valid || !in_stall) begin
				if (pending.size() > 0 && !hold_in && $urandom_range(99) >= send_idle) begin
					cur = pending.pop_front();
					packed_nibbles <= cur.nib;
					low_activations <= cur.act_lo;
					high_activations <= cur.act_hi;
					weight_scale <= cur.wscale;
					activation_scale <= cur.ascale;
					last_of_row <= cur.last;
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk)
		out_stall <= ($urandom_range(99) < recv_idle);

	// monitor
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (sum_expect.size() == 0) begin
				$error("unexpected sum_bits transfer: %h", sum_bits);
				fails++;
			end else begin
				if (sum_bits !== sum_expect[0]) begin
					$error("sum_bits: expected %h, actual %h", sum_expect[0], sum_bits);
					fails++;
				end
				void'(sum_expect.pop_front());
			end
		end
	end

	function automatic logic [63:0] rnd64();
		return {$urandom, $urandom};
	endfunction

	function automatic logic [63:0] rnd_data();
		case ($urandom_range(9))
			0: return '0;
			1: return '1;
			2: return {8{8'h80}};
			3: return {8{8'h7F}};
			default: return rnd64();
		endcase
	endfunction

	function automatic logic [15:0] rnd_scale();
		if ($urandom_range(9) < 8)
			return {1'($urandom), 5'($urandom_range(8, 20)), 10'($urandom)};
		return 16'($urandom);
	endfunction

	task automatic add_item(input logic [63:0] n, input logic [63:0] lo, input logic [63:0] hi,
			input logic [15:0] ws, input logic [15:0] as, input logic l);
		half_blk_t it;
		it.nib = n;
		it.act_lo = lo;
		it.act_hi = hi;
		it.wscale = ws;
		it.ascale = as;
		it.last = l;
		pending.push_back(it);
	endtask

	task automatic add_rows(input int n_items);
		int cnt, blocks;
		cnt = 0;
		while (cnt < n_items) begin
			blocks = $urandom_range(1, 5);
			for (int b = 0; b < blocks; b++) begin
				// scales on a first half are noise
				add_item(rnd_data(), rnd_data(), rnd_data(), 16'($urandom), 16'($urandom), 1'b0);
				if (b == blocks - 1 && $urandom_range(9) == 0) begin
					add_item(rnd_data(), rnd_data(), rnd_data(), 16'($urandom), 16'($urandom), 1'b1);
				end else begin
					add_item(rnd_data(), rnd_data(), rnd_data(), rnd_scale(), rnd_scale(),
						b == blocks - 1);
				end
				cnt += 2;
			end
		end
	endtask

	task automatic drain();
		while (pending.size() > 0 || in_valid || sum_expect.size() > 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	initial begin
		pr_second = 1'b0;
		pr_blk_sum = 0;
		pr_running = 32'd0;
		#1 arst_n = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// extremes: largest positive lane sums, then large negative lane sums
		add_item('0, {8{8'h80}}, {8{8'h80}}, 16'h3C00, 16'h3C00, 1'b0);
		add_item('0, {8{8'h80}}, {8{8'h80}}, 16'h3C00, 16'h3C00, 1'b1);
		add_item('1, {8{8'h80}}, {8{8'h80}}, 16'hABCD, 16'h1234, 1'b0);
		add_item('1, {8{8'h80}}, {8{8'h7F}}, 16'hBC00, 16'h7BFF, 1'b1);
		add_item('0, '1, '0, 16'h0, 16'h0, 1'b0);
		add_item({8{8'h88}}, '1, '1, 16'h0001, 16'h03FF, 1'b1);
		// empty row, then last on a first half
		add_item('0, '0, '0, '0, '0, 1'b1);
		add_item(rnd64(), rnd64(), rnd64(), 16'h3C00, 16'h3C00, 1'b0);
		add_item(rnd64(), rnd64(), rnd64(), 16'h4000, 16'h3800, 1'b0);
		add_item(rnd64(), rnd64(), rnd64(), '1, '1, 1'b1);
		// scale specials: inf, nan, signed zero, subnormal
		add_item('1, {8{8'h01}}, '0, '0, '0, 1'b0);
		add_item('1, '0, '0, 16'h7C00, 16'h3C00, 1'b1);
		add_item('0, '0, '0, '0, '0, 1'b0);
		add_item('0, '0, '0, 16'h7C00, 16'h3C00, 1'b1);
		add_item(rnd64(), rnd64(), rnd64(), '0, '0, 1'b0);
		add_item(rnd64(), rnd64(), rnd64(), 16'h7E01, 16'h3C00, 1'b0);
		add_item(rnd64(), rnd64(), rnd64(), '0, '0, 1'b0);
		add_item(rnd64(), rnd64(), rnd64(), 16'hFC00, 16'h7C00, 1'b1);
		add_item('1, {8{8'h01}}, {8{8'h01}}, '0, '0, 1'b0);
		add_item('1, {8{8'h01}}, {8{8'h01}}, 16'h8000, 16'h3C00, 1'b1);
		add_item('1, {8{8'h01}}, '0, '0, '0, 1'b0);
		add_item('1, {8{8'h01}}, '0, 16'h0001, 16'h0001, 1'b1);

		send_idle = 9;
		recv_idle = 69;
		add_rows(110);
		drain();
		// mid-stream, hold the sender until every expected result is out
		add_rows(110);
		repeat (200) @(posedge clk);
		hold_in = 1'b1;
		while (in_valid || sum_expect.size() > 0) @(posedge clk);
		repeat (20) @(posedge clk);
		hold_in = 1'b0;
		drain();

		send_idle = 69;
		recv_idle = 9;
		add_rows(210);
		drain();

		send_idle = 0;
		recv_idle = 0;
		add_rows(200);
		drain();

		if (fails == 0 && sum_expect.size() == 0)
			$display("** q4_q8_block_dot_product: PASSED **");
		else
			$display("** q4_q8_block_dot_product: FAILED **");
		$finish;
	end

	initial begin
		#3000000;
		$display("** q4_q8_block_dot_product: FAILED **");
		$finish;
	end

endmodule

[q4_q8_block_dot_product.f]
+incdir+rtl/core
rtl/core/qdp_pkg.sv
rtl/core/qdp_lanes.sv
rtl/core/qdp_fpu.sv
rtl/core/q4_q8_block_dot_product.sv
test/q4_q8_block_dot_product_tb.sv
